// File: rtl/core/wdst_pkg.sv
// types, constants and codes shared by the window descriptor slot table
// no dependencies; wdst_cell and the top level in rtl/core refer to this package
`default_nettype none

package wdst_pkg;

  // table geometry
  localparam int SLOTS  = 16;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int SLOT_W = 4;

  // operation codes
  typedef enum logic [2:0] {
    OP_ADD       = 3'd0,
    OP_REM_MATCH = 3'd1,
    OP_REM_SLOT  = 3'd2,
    OP_MOVE      = 3'd3,
    OP_RESIZE    = 3'd4,
    OP_FIND      = 3'd5
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMATCH = 2'd1,
    ST_FULL    = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_t;

  // one window descriptor as held in a cell
  typedef struct packed {
    logic [15:0] clip_h;
    logic [15:0] clip_w;
    logic [15:0] clip_y;
    logic [15:0] clip_x;
    logic [15:0] image_id;
    logic [15:0] pos_y;
    logic [15:0] pos_x;
    logic [15:0] height;
    logic [15:0] width;
  } desc_t;

  // control broadcast from the controller to every cell
  typedef struct packed {
    logic adv;      // move the scan token one cell along
    logic clr;      // drop the scan token
    logic wr_size;  // selected cell takes width and height
    logic wr_pos;   // selected cell takes position
    logic wr_rest;  // selected cell takes image index and clip rectangle
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/wdst_if.sv
// request and response channel interfaces of the window descriptor slot table
// depends on nothing; used by the top level
`default_nettype none

interface wdst_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [3:0]         slot;
  logic [15:0]        width;
  logic [15:0]        height;
  logic [15:0]        pos_x;
  logic [15:0]        pos_y;
  logic [15:0]        image_id;
  logic signed [15:0] clip_x;
  logic signed [15:0] clip_y;
  logic [15:0]        clip_w;
  logic [15:0]        clip_h;

  modport source (
    output valid, operation, slot, width, height, pos_x, pos_y, image_id,
           clip_x, clip_y, clip_w, clip_h,
    input  ready
  );
  modport sink (
    input  valid, operation, slot, width, height, pos_x, pos_y, image_id,
           clip_x, clip_y, clip_w, clip_h,
    output ready
  );
endinterface

interface wdst_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] slot_found;
  logic [1:0] status;

  modport source (output valid, slot_found, status, input ready);
  modport sink   (input valid, slot_found, status, output ready);
endinterface

`default_nettype wire

// File: rtl/core/wdst_cell.sv
// one slot of the table: descriptor storage, match compare and scan token stage
// depends on wdst_pkg
`default_nettype none

module wdst_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire wdst_pkg::cell_ctl_t ctl,
  input  wire logic               sel,
  input  wire wdst_pkg::desc_t    wdata,
  input  wire wdst_pkg::desc_t    key,
  input  wire logic               tok_in,
  output logic                    tok,
  output logic                    hit
);

  wdst_pkg::desc_t desc;

  // scan token, handed on from the left neighbor
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      tok <= 1'b0;
    end else if (ctl.adv) begin
      tok <= tok_in;
    end
  end

  // descriptor storage, no reset
  always_ff @(posedge clk) begin
    if (sel) begin
      if (ctl.wr_size) begin
        desc.width  <= wdata.width;
        desc.height <= wdata.height;
      end
      if (ctl.wr_pos) begin
        desc.pos_x <= wdata.pos_x;
        desc.pos_y <= wdata.pos_y;
      end
      if (ctl.wr_rest) begin
        desc.image_id <= wdata.image_id;
        desc.clip_x   <= wdata.clip_x;
        desc.clip_y   <= wdata.clip_y;
        desc.clip_w   <= wdata.clip_w;
        desc.clip_h   <= wdata.clip_h;
      end
    end
  end

  // match only where the token sits
  assign hit = tok && (desc == key);

endmodule

`default_nettype wire

// File: rtl/core/window_descriptor_slot_table.sv
// top level of the window descriptor slot table: controller and chain of cells
// depends on wdst_pkg, wdst_if and wdst_cell
//
//   channel  dir  modport  beat
//   req      in   sink     one operation with slot number and descriptor
//   rsp      out  source   slot_found and status, one per request
//
// slot ops (remove at slot, move, resize) and unused codes go from accept through
// EXEC and DONE to the result register. add, remove matching and find also pass
// through SCAN, where the scan token walks past at most SLOTS cells, one cell per
// cycle along the chain. the controller returns to IDLE before the next accept.
// reset clears used_count and the scan token; descriptor contents stay
// undefined and need no clearing pass.
// a result waits in the output register under back-pressure; the next request
// is accepted as soon as the result has moved into that register.
`default_nettype none

module window_descriptor_slot_table (
  input  wire logic clk,
  input  wire logic rst,
  wdst_req_if.sink   req,
  wdst_rsp_if.source rsp
);

  localparam int N = wdst_pkg::SLOTS;

  wdst_pkg::state_t  state, state_next;
  wdst_pkg::op_t     op_q;
  logic [3:0]        slot_q;
  wdst_pkg::desc_t   data_q;
  logic [wdst_pkg::CNT_W-1:0] used_count, used_count_next;
  logic [wdst_pkg::CNT_W-1:0] pos, pos_next;
  logic [3:0]        res_slot, res_slot_next;
  wdst_pkg::status_t res_status, res_status_next;
  logic              rsp_valid, rsp_valid_next;
  logic              rsp_load;

  wdst_pkg::cell_ctl_t ctl;
  logic              tok_first;
  logic              wr_go;
  logic              clear_data;
  logic [wdst_pkg::IDX_W-1:0] widx;
  logic [N-1:0]      sel;
  logic [N:0]        tok_chain;
  logic [N-1:0]      hit_vec;
  logic              hit;
  logic              in_range;
  wdst_pkg::desc_t   key;
  wdst_pkg::desc_t   wdata;

  assign req.ready  = (state == wdst_pkg::S_IDLE);
  assign rsp.valid  = rsp_valid;

  // scan key is all zero for add, the request descriptor otherwise
  assign key       = (op_q == wdst_pkg::OP_ADD) ? '0 : data_q;
  assign wdata     = clear_data ? '0 : data_q;
  assign hit       = |hit_vec;
  assign in_range  = 32'(slot_q) < 32'(used_count);
  assign tok_chain[0] = tok_first;

  // write select decode
  always_comb begin
    for (int i = 0; i < N; i++) begin
      sel[i] = wr_go && (widx == wdst_pkg::IDX_W'(i));
    end
  end

  // chain of cells, token handed left to right
  for (genvar g = 0; g < N; g++) begin : g_cell
    wdst_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .sel    (sel[g]),
      .wdata  (wdata),
      .key    (key),
      .tok_in (tok_chain[g]),
      .tok    (tok_chain[g+1]),
      .hit    (hit_vec[g])
    );
  end

  // state register and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= wdst_pkg::S_IDLE;
      used_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      used_count <= used_count_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos        <= pos_next;
    res_slot   <= res_slot_next;
    res_status <= res_status_next;
    if (req.valid && req.ready) begin
      op_q            <= wdst_pkg::op_t'(req.operation);
      slot_q          <= req.slot;
      data_q.width    <= req.width;
      data_q.height   <= req.height;
      data_q.pos_x    <= req.pos_x;
      data_q.pos_y    <= req.pos_y;
      data_q.image_id <= req.image_id;
      data_q.clip_x   <= req.clip_x;
      data_q.clip_y   <= req.clip_y;
      data_q.clip_w   <= req.clip_w;
      data_q.clip_h   <= req.clip_h;
    end
    if (rsp_load) begin
      rsp.slot_found <= res_slot;
      rsp.status     <= res_status;
    end
  end

  // next state, cell control and result
  always_comb begin
    state_next      = state;
    used_count_next = used_count;
    pos_next        = pos;
    res_slot_next   = res_slot;
    res_status_next = res_status;
    ctl             = '0;
    tok_first       = 1'b0;
    wr_go           = 1'b0;
    clear_data      = 1'b0;
    widx            = wdst_pkg::IDX_W'(slot_q);
    rsp_load        = 1'b0;
    rsp_valid_next  = rsp_valid && !rsp.ready;

    case (state)
      wdst_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = wdst_pkg::S_EXEC;
        end
      end

      wdst_pkg::S_EXEC: begin
        res_slot_next   = '0;
        res_status_next = wdst_pkg::ST_OK;
        state_next      = wdst_pkg::S_DONE;
        case (op_q)
          wdst_pkg::OP_ADD, wdst_pkg::OP_REM_MATCH, wdst_pkg::OP_FIND: begin
            // token enters the first cell
            ctl.adv    = 1'b1;
            tok_first  = 1'b1;
            pos_next   = '0;
            state_next = wdst_pkg::S_SCAN;
          end
          wdst_pkg::OP_REM_SLOT, wdst_pkg::OP_MOVE, wdst_pkg::OP_RESIZE: begin
            if (in_range) begin
              wr_go         = 1'b1;
              res_slot_next = slot_q;
              if (op_q == wdst_pkg::OP_REM_SLOT) begin
                clear_data  = 1'b1;
                ctl.wr_size = 1'b1;
                ctl.wr_pos  = 1'b1;
                ctl.wr_rest = 1'b1;
              end else if (op_q == wdst_pkg::OP_MOVE) begin
                ctl.wr_pos  = 1'b1;
              end else begin
                ctl.wr_size = 1'b1;
              end
            end else begin
              res_status_next = wdst_pkg::ST_RANGE;
            end
          end
          default: begin
          end
        endcase
      end

      wdst_pkg::S_SCAN: begin
        ctl.wr_size = 1'b1;
        ctl.wr_pos  = 1'b1;
        ctl.wr_rest = 1'b1;
        if (pos >= used_count) begin
          // ran past the used slots
          ctl.clr    = 1'b1;
          state_next = wdst_pkg::S_DONE;
          res_slot_next = '0;
          if (op_q == wdst_pkg::OP_ADD) begin
            if (32'(used_count) < 32'(N)) begin
              wr_go           = 1'b1;
              widx            = wdst_pkg::IDX_W'(used_count);
              used_count_next = used_count + wdst_pkg::CNT_W'(1);
              res_slot_next   = 4'(used_count);
              res_status_next = wdst_pkg::ST_OK;
            end else begin
              res_status_next = wdst_pkg::ST_FULL;
            end
          end else begin
            res_status_next = wdst_pkg::ST_NOMATCH;
          end
        end else if (hit) begin
          // first equal slot found
          ctl.clr         = 1'b1;
          state_next      = wdst_pkg::S_DONE;
          widx            = wdst_pkg::IDX_W'(pos);
          res_slot_next   = 4'(pos);
          res_status_next = wdst_pkg::ST_OK;
          wr_go           = (op_q != wdst_pkg::OP_FIND);
          clear_data      = (op_q == wdst_pkg::OP_REM_MATCH);
        end else begin
          ctl.adv  = 1'b1;
          pos_next = pos + wdst_pkg::CNT_W'(1);
        end
      end

      wdst_pkg::S_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_load       = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = wdst_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = wdst_pkg::S_IDLE;
      end
    endcase
  end

  // used count only ever grows by one
  a_used_step: assert property (@(posedge clk) disable iff (rst)
    used_count != $past(used_count) |-> used_count == $past(used_count) + wdst_pkg::CNT_W'(1))
    else $error("used count jumped");

  // at most one token in the chain
  a_tok_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_chain[N:1]))
    else $error("more than one scan token");

  // token only lives during a scan
  a_tok_scan: assert property (@(posedge clk) disable iff (rst)
    (|tok_chain[N:1]) |-> state == wdst_pkg::S_SCAN)
    else $error("scan token outside scan");

  // error results carry slot zero
  a_err_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != wdst_pkg::ST_OK |-> rsp.slot_found == 4'd0)
    else $error("error result with nonzero slot");

  // used count never exceeds the table size
  a_used_max: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> 32'(used_count) <= 32'(N))
    else $error("used count beyond table size");

endmodule

`default_nettype wire
